### rtl/core/lca_parent_climb_defines.svh
// Assertion helpers used by the checker file lca_chk.
`ifndef LCA_PARENT_CLIMB_DEFINES_SVH
`define LCA_PARENT_CLIMB_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LCA_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LCA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/lca_pkg.sv
package lca_pkg;

   localparam int NODE_W      = 10;
   localparam int ENTRY_W     = NODE_W + 1;
   localparam int ROOT_BIT    = NODE_W;
   localparam int STORE_DEPTH = 1 << NODE_W;
   localparam int MAX_NODES   = 1024;
   localparam int DEPTH_W     = $clog2(MAX_NODES + 1);

   localparam logic [ENTRY_W-1:0] ROOT_MARK = {1'b1, {NODE_W{1'b0}}};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              is_root;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              fault;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic wr_en;
      logic load;
      logic restore;
      logic step_a;
      logic step_b;
      logic count_down;
      logic out_load;
      logic out_fault;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic root_a;
      logic root_b;
      logic over_a;
      logic over_b;
      logic a_deeper;
      logic b_deeper;
      logic same;
      logic depth_zero;
   } dp_status_type;

endpackage

### rtl/core/lca_dpath.sv
module lca_dpath (
   input  logic                  clock,
   input  lca_pkg::req_type      req_data,
   input  lca_pkg::dp_cmd_type   ctl,
   output lca_pkg::dp_status_type status,
   output lca_pkg::rsp_type      rsp_data
);
   import lca_pkg::*;

   logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rda_ff, rdb_ff;
   logic [ENTRY_W-1:0] wr_word;

   logic [NODE_W-1:0]  ua_ff, ub_ff, ua_in, ub_in;
   logic [NODE_W-1:0]  qa_ff, qb_ff;
   logic [DEPTH_W-1:0] da_ff, db_ff, da_in, db_in;
   rsp_type            rsp_ff;

   assign wr_word = req_data.is_root ? ROOT_MARK : {1'b0, req_data.node_b};

   // parent table: one write port, two registered read ports following the climb pointers
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[req_data.node_a] <= wr_word;
      end
      rda_ff <= store_mem[ua_ff];
      rdb_ff <= store_mem[ub_ff];
   end

   always_comb begin
      ua_in = ua_ff;
      ub_in = ub_ff;
      da_in = da_ff;
      db_in = db_ff;
      if (ctl.load) begin
         ua_in = req_data.node_a;
         ub_in = req_data.node_b;
         da_in = '0;
         db_in = '0;
      end else if (ctl.restore) begin
         ua_in = qa_ff;
         ub_in = qb_ff;
      end else begin
         if (ctl.step_a) begin
            ua_in = rda_ff[NODE_W-1:0];
            da_in = ctl.count_down ? da_ff - 1'b1 : da_ff + 1'b1;
         end
         if (ctl.step_b) begin
            ub_in = rdb_ff[NODE_W-1:0];
            db_in = ctl.count_down ? db_ff - 1'b1 : db_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ua_ff <= ua_in;
      ub_ff <= ub_in;
      da_ff <= da_in;
      db_ff <= db_in;
      if (ctl.load) begin
         qa_ff <= req_data.node_a;
         qb_ff <= req_data.node_b;
      end
      if (ctl.out_load) begin
         rsp_ff.ancestor <= ctl.out_fault ? '0 : ua_ff;
         rsp_ff.fault    <= ctl.out_fault;
      end
   end

   assign status.root_a     = rda_ff[ROOT_BIT];
   assign status.root_b     = rdb_ff[ROOT_BIT];
   assign status.over_a     = da_ff >= DEPTH_W'(MAX_NODES);
   assign status.over_b     = db_ff >= DEPTH_W'(MAX_NODES);
   assign status.a_deeper   = da_ff > db_ff;
   assign status.b_deeper   = db_ff > da_ff;
   assign status.same       = ua_ff == ub_ff;
   assign status.depth_zero = da_ff == '0;

   assign rsp_data = rsp_ff;

endmodule

### rtl/core/lca_ctrl.sv
module lca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_query,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lca_pkg::dp_status_type status,
   output lca_pkg::dp_cmd_type    ctl
);
   import lca_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DWAIT  = 8'b0000_0010,
      ST_DEVAL  = 8'b0000_0100,
      ST_EWAIT  = 8'b0000_1000,
      ST_EEVAL  = 8'b0001_0000,
      ST_MWAIT  = 8'b0010_0000,
      ST_MEVAL  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      done_a_ff, done_a_in, done_b_ff, done_b_in;
   logic      fault_ff, fault_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fin_a, fin_b, bad_a, bad_b;

   assign fin_a = done_a_ff | status.root_a;
   assign fin_b = done_b_ff | status.root_b;
   assign bad_a = !fin_a && status.over_a;
   assign bad_b = !fin_b && status.over_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      done_a_in    = done_a_ff;
      done_b_in    = done_b_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_query == CMD_QUERY) begin
                  ctl.load  = 1'b1;
                  done_a_in = 1'b0;
                  done_b_in = 1'b0;
                  fault_in  = 1'b0;
                  state_in  = ST_DWAIT;
               end else begin
                  ctl.wr_en = 1'b1;
               end
            end
         end
         ST_DWAIT: state_in = ST_DEVAL;
         ST_DEVAL: begin
            // climb both nodes to their roots to count depths
            if (bad_a || bad_b) begin
               fault_in = 1'b1;
               state_in = ST_FINISH;
            end else if (fin_a && fin_b) begin
               ctl.restore = 1'b1;
               state_in    = ST_EWAIT;
            end else begin
               ctl.step_a = !fin_a;
               ctl.step_b = !fin_b;
               done_a_in  = fin_a;
               done_b_in  = fin_b;
               state_in   = ST_DWAIT;
            end
         end
         ST_EWAIT: state_in = ST_EEVAL;
         ST_EEVAL: begin
            ctl.count_down = 1'b1;
            if (status.a_deeper) begin
               ctl.step_a = 1'b1;
               state_in   = ST_EWAIT;
            end else if (status.b_deeper) begin
               ctl.step_b = 1'b1;
               state_in   = ST_EWAIT;
            end else begin
               // read data still matches the pointers
               state_in = ST_MEVAL;
            end
         end
         ST_MWAIT: state_in = ST_MEVAL;
         ST_MEVAL: begin
            ctl.count_down = 1'b1;
            if (status.same) begin
               fault_in = 1'b0;
               state_in = ST_FINISH;
            end else if (status.depth_zero) begin
               // reached different roots
               fault_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               ctl.step_a = 1'b1;
               ctl.step_b = 1'b1;
               state_in   = ST_MWAIT;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.out_load  = 1'b1;
               ctl.out_fault = fault_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_a_ff    <= 1'b0;
         done_b_ff    <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_a_ff    <= done_a_in;
         done_b_ff    <= done_b_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/lca_parent_climb.sv
// Lowest common ancestor over a stored parent table (1024 nodes).
// Input channel req_*: one word per item. cmd write stores the parent of node_a
// (node_b, or a root mark when is_root is set); cmd query asks for the lowest
// common ancestor of node_a and node_b. Writes give no result word; each query
// gives exactly one word on rsp_* (ancestor, fault).
// A query climbs the parent table one step at a time, each step a registered
// table read and then an evaluate state; a broken table faults once a climb's
// depth count reaches MAX_NODES. No new request is taken while a query runs.
// The table has one write port and two read ports, one per climbing pointer.
// The result sits in an output register: while the receiver stalls it holds
// the word, and the block keeps taking writes and works on the next query,
// waiting only when that query's result is ready and the register is still full.
// Reset clears the controller and the output valid; the parent table is not
// cleared, so every node a query reaches must have been written first.
// fault is 1 (with ancestor 0) for a cycle, a too-long climb, or separate trees.
module lca_parent_climb (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lca_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lca_pkg::rsp_type rsp_data
);
   import lca_pkg::*;

   dp_cmd_type    ctl;
   dp_status_type status;

   lca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_query (req_data.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   lca_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .ctl      (ctl),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/core/lca_chk.sv
`include "lca_parent_climb_defines.svh"

module lca_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input lca_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lca_pkg::rsp_type rsp_data
);
   import lca_pkg::*;

   `LCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
   `LCA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp word changed while stalled")
   `LCA_ASSERT_NOW(a_fault_zero, clock, reset, rsp_valid && rsp_data.fault, rsp_data.ancestor == '0, "fault with nonzero ancestor")
   `LCA_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_data.cmd == CMD_QUERY, !req_ready, "ready right after a query")

endmodule

bind lca_parent_climb lca_chk u_lca_chk (.*);
